// ----- rtl/ffa_pkg.sv -----
package ffa_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;
    localparam logic [15:0] HEAP_RESET = 16'd3000;

    // result codes carried in the status field
    typedef enum logic [2:0] {
        ST_ALLOCATED = 3'd0,
        ST_NO_FIT    = 3'd1,
        ST_FREED     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // request opcodes
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    // datapath commands issued by the controller
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_FIND,
        CMD_FSCAN,
        CMD_FAPPLY,
        CMD_FIT,
        CMD_FITAPPLY,
        CMD_OSCAN,
        CMD_OINSERT,
        CMD_RESULT
    } cmd_t;

    typedef struct packed {
        cmd_t    op;
        status_t code;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic is_free;
        logic free_fail;
        logic own_full;
        logic fit_fail;
        logic out_free;
    } dp_sts_t;

endpackage

// ----- rtl/ffa_ctrl.sv -----
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_FIND     = 9'b000000010,
        S_FSCAN    = 9'b000000100,
        S_FAPPLY   = 9'b000001000,
        S_FIT      = 9'b000010000,
        S_FITAPPLY = 9'b000100000,
        S_OSCAN    = 9'b001000000,
        S_OINSERT  = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    assign s_tready = (state_reg == S_IDLE);

    // sequencing of the scans and table updates
    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd.op     = CMD_NONE;
        cmd.code   = code_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_FIND;
                end
            end
            S_FIND: begin
                cmd.op = CMD_FIND;
                if (sts.scan_done) begin
                    if (sts.found) begin
                        state_next = S_FSCAN;
                    end else if (sts.is_free) begin
                        code_next  = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end else if (sts.own_full) begin
                        code_next  = ST_FULL;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_FIT;
                    end
                end
            end
            S_FSCAN: begin
                cmd.op = CMD_FSCAN;
                if (sts.scan_done) begin
                    state_next = S_FAPPLY;
                end
            end
            S_FAPPLY: begin
                cmd.op = CMD_FAPPLY;
                if (sts.free_fail) begin
                    code_next  = ST_FULL;
                    state_next = S_DONE;
                end else if (sts.is_free) begin
                    code_next  = ST_FREED;
                    state_next = S_DONE;
                end else begin
                    state_next = S_FIT;
                end
            end
            S_FIT: begin
                cmd.op = CMD_FIT;
                if (sts.scan_done) begin
                    if (sts.fit_fail) begin
                        code_next  = ST_NO_FIT;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_FITAPPLY;
                    end
                end
            end
            S_FITAPPLY: begin
                cmd.op     = CMD_FITAPPLY;
                state_next = S_OSCAN;
            end
            S_OSCAN: begin
                cmd.op = CMD_OSCAN;
                if (sts.scan_done) begin
                    state_next = S_OINSERT;
                end
            end
            S_OINSERT: begin
                cmd.op     = CMD_OINSERT;
                code_next  = ST_ALLOCATED;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.op     = CMD_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= ST_ALLOCATED;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

// ----- rtl/ffa_datapath.sv -----
module ffa_datapath
    import ffa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tuser,
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    input  ctrl_cmd_t   cmd,
    output dp_sts_t     sts
);

    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam logic [CW-1:0] FULL = CW'(MAX_SEGMENTS);

    // tables
    logic [15:0]   free_start_reg [MAX_SEGMENTS];
    logic [15:0]   free_size_reg  [MAX_SEGMENTS];
    logic [15:0]   own_id_reg     [MAX_SEGMENTS];
    logic [15:0]   own_start_reg  [MAX_SEGMENTS];
    logic [15:0]   own_size_reg   [MAX_SEGMENTS];
    logic [CW-1:0] free_cnt_reg, own_cnt_reg;

    // request and working registers
    logic          op_reg;
    logic [15:0]   id_reg, req_reg;
    logic [CW-1:0] idx_reg, k_reg, p_reg, fi_reg;
    logic [15:0]   s_reg, z_reg, prev_size_reg, next_size_reg, fs_reg, fz_reg;
    logic [16:0]   prev_end_reg;
    logic          adj_prev_reg, adj_next_reg, replaced_reg;
    logic          m_valid_reg;
    logic [39:0]   m_data_reg;

    logic [IW-1:0] ri;
    logic [15:0]   rd_fstart, rd_fsize, rd_oid, rd_ostart, rd_osize;
    logic          in_free, in_own, cont;
    logic [16:0]   s_end;

    assign ri        = idx_reg[IW-1:0];
    assign rd_fstart = free_start_reg[ri];
    assign rd_fsize  = free_size_reg[ri];
    assign rd_oid    = own_id_reg[ri];
    assign rd_ostart = own_start_reg[ri];
    assign rd_osize  = own_size_reg[ri];
    assign in_free   = (idx_reg < free_cnt_reg);
    assign in_own    = (idx_reg < own_cnt_reg);
    assign s_end     = {1'b0, s_reg} + {1'b0, z_reg};

    // scan continuation per command
    always_comb begin
        unique case (cmd.op)
            CMD_FIND:  cont = in_own && (rd_oid != id_reg);
            CMD_FSCAN: cont = in_free && (rd_fstart <= s_reg);
            CMD_FIT:   cont = in_free && (rd_fsize < req_reg);
            CMD_OSCAN: cont = in_own && (rd_ostart < fs_reg);
            default:   cont = 1'b0;
        endcase
    end

    // status towards the controller
    always_comb begin
        sts.scan_done = !cont;
        sts.found     = in_own;
        sts.is_free   = op_reg;
        sts.free_fail = !adj_prev_reg && !adj_next_reg && (free_cnt_reg >= FULL);
        sts.own_full  = (own_cnt_reg >= FULL);
        sts.fit_fail  = (req_reg == 16'd0) || !in_free;
        sts.out_free  = !m_valid_reg || m_tready;
    end

    // working registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            CMD_LOAD: begin
                op_reg       <= s_tuser;
                id_reg       <= s_tdata[15:0];
                req_reg      <= s_tdata[31:16];
                idx_reg      <= '0;
                replaced_reg <= 1'b0;
                prev_end_reg <= '0;
            end
            CMD_FIND: begin
                if (cont) begin
                    idx_reg <= idx_reg + 1'b1;
                end else begin
                    k_reg        <= idx_reg;
                    s_reg        <= rd_ostart;
                    z_reg        <= rd_osize;
                    idx_reg      <= '0;
                    prev_end_reg <= '0;
                end
            end
            CMD_FSCAN: begin
                if (cont) begin
                    prev_end_reg  <= {1'b0, rd_fstart} + {1'b0, rd_fsize};
                    prev_size_reg <= rd_fsize;
                    idx_reg       <= idx_reg + 1'b1;
                end else begin
                    p_reg         <= idx_reg;
                    next_size_reg <= rd_fsize;
                    adj_prev_reg  <= (idx_reg != '0) && (prev_end_reg == {1'b0, s_reg});
                    adj_next_reg  <= in_free && (s_end == {1'b0, rd_fstart});
                    idx_reg       <= '0;
                end
            end
            CMD_FAPPLY: begin
                if (!sts.free_fail && !op_reg) begin
                    replaced_reg <= 1'b1;
                end
            end
            CMD_FIT: begin
                if (cont) begin
                    idx_reg <= idx_reg + 1'b1;
                end else begin
                    fi_reg  <= idx_reg;
                    fs_reg  <= rd_fstart;
                    fz_reg  <= rd_fsize;
                    idx_reg <= '0;
                end
            end
            CMD_OSCAN: begin
                if (cont) begin
                    idx_reg <= idx_reg + 1'b1;
                end else begin
                    p_reg   <= idx_reg;
                    idx_reg <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    // table updates
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            free_start_reg[0] <= 16'd0;
            free_size_reg[0]  <= aresetn ? cfg_wr_data : HEAP_RESET;
            free_cnt_reg      <= (aresetn ? (cfg_wr_data != 16'd0) : 1'b1) ? CW'(1) : '0;
            own_cnt_reg       <= '0;
        end else begin
            unique case (cmd.op)
                CMD_FAPPLY: begin
                    if (!sts.free_fail) begin
                        // remove the owned entry
                        for (int j = 0; j < MAX_SEGMENTS - 1; j++) begin
                            if (CW'(j) >= k_reg) begin
                                own_id_reg[j]    <= own_id_reg[j+1];
                                own_start_reg[j] <= own_start_reg[j+1];
                                own_size_reg[j]  <= own_size_reg[j+1];
                            end
                        end
                        own_cnt_reg <= own_cnt_reg - 1'b1;
                        // return the block and merge with neighbours
                        for (int j = 0; j < MAX_SEGMENTS; j++) begin
                            if (adj_prev_reg && adj_next_reg) begin
                                if (CW'(j) == p_reg - 1'b1) begin
                                    free_size_reg[j] <= prev_size_reg + z_reg + next_size_reg;
                                end else if (CW'(j) >= p_reg && j < MAX_SEGMENTS - 1) begin
                                    free_start_reg[j] <= free_start_reg[j+1];
                                    free_size_reg[j]  <= free_size_reg[j+1];
                                end
                            end else if (adj_prev_reg) begin
                                if (CW'(j) == p_reg - 1'b1) begin
                                    free_size_reg[j] <= prev_size_reg + z_reg;
                                end
                            end else if (adj_next_reg) begin
                                if (CW'(j) == p_reg) begin
                                    free_start_reg[j] <= s_reg;
                                    free_size_reg[j]  <= next_size_reg + z_reg;
                                end
                            end else begin
                                if (CW'(j) == p_reg) begin
                                    free_start_reg[j] <= s_reg;
                                    free_size_reg[j]  <= z_reg;
                                end else if (CW'(j) > p_reg) begin
                                    free_start_reg[j] <= free_start_reg[j-1];
                                    free_size_reg[j]  <= free_size_reg[j-1];
                                end
                            end
                        end
                        if (adj_prev_reg && adj_next_reg) begin
                            free_cnt_reg <= free_cnt_reg - 1'b1;
                        end else if (!adj_prev_reg && !adj_next_reg) begin
                            free_cnt_reg <= free_cnt_reg + 1'b1;
                        end
                    end
                end
                CMD_FITAPPLY: begin
                    // shrink the segment from the front or drop it
                    for (int j = 0; j < MAX_SEGMENTS; j++) begin
                        if (fz_reg > req_reg) begin
                            if (CW'(j) == fi_reg) begin
                                free_start_reg[j] <= fs_reg + req_reg;
                                free_size_reg[j]  <= fz_reg - req_reg;
                            end
                        end else if (CW'(j) >= fi_reg && j < MAX_SEGMENTS - 1) begin
                            free_start_reg[j] <= free_start_reg[j+1];
                            free_size_reg[j]  <= free_size_reg[j+1];
                        end
                    end
                    if (fz_reg <= req_reg) begin
                        free_cnt_reg <= free_cnt_reg - 1'b1;
                    end
                end
                CMD_OINSERT: begin
                    // open a slot at the insert point
                    for (int j = 0; j < MAX_SEGMENTS; j++) begin
                        if (CW'(j) == p_reg) begin
                            own_id_reg[j]    <= id_reg;
                            own_start_reg[j] <= fs_reg;
                            own_size_reg[j]  <= req_reg;
                        end else if (CW'(j) > p_reg) begin
                            own_id_reg[j]    <= own_id_reg[j-1];
                            own_start_reg[j] <= own_start_reg[j-1];
                            own_size_reg[j]  <= own_size_reg[j-1];
                        end
                    end
                    own_cnt_reg <= own_cnt_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == CMD_RESULT) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == CMD_RESULT) begin
            unique case (cmd.code)
                ST_ALLOCATED: m_data_reg <= {4'd0, replaced_reg, req_reg, fs_reg, cmd.code};
                ST_FREED:     m_data_reg <= {4'd0, 1'b0, z_reg, s_reg, cmd.code};
                ST_NO_FIT:    m_data_reg <= {4'd0, replaced_reg, 32'd0, cmd.code};
                default:      m_data_reg <= {4'd0, 1'b0, 32'd0, cmd.code};
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- rtl/first_fit_allocator_core.sv -----
// sequence: up to four table scans (owner lookup, free-list position, first fit
//   and owned-table insert point) lie between input beat and result beat
// throughput: one request at a time; each scan steps one table entry a cycle
// reset: aresetn synchronous, active low; heap_size returns to 3000, the free
//   table holds one segment [0, heap_size) and no block is owned
module first_fit_allocator_core
    import ffa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,  // heap_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,      // opcode
    input  logic [31:0] s_tdata,      // owner_id, request_size
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata       // status, block_start, block_size, replaced_previous
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // sequencer
    ffa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tables and result register
    ffa_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ----- rtl/ffa_checker.sv -----
module ffa_checker
    import ffa_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed under stall");

    // status code in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= ST_FULL)
        else $error("status out of range");

    // failed requests carry no block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == ST_NO_FIT || m_tdata[2:0] == ST_NOT_FOUND ||
                     m_tdata[2:0] == ST_FULL) |-> m_tdata[34:3] == 32'd0)
        else $error("failed result with block fields");

    // replacement only reported for allocates that got past the free
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[35] |-> m_tdata[2:0] == ST_ALLOCATED ||
                                    m_tdata[2:0] == ST_NO_FIT)
        else $error("replacement flag on wrong status");

endmodule

bind first_fit_allocator_core ffa_checker u_ffa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
